// ===== rtl/core/oale_pkg.sv =====
`timescale 1ns / 1ps

package oale_pkg;

  // Default number of list cells.
  localparam int unsigned DEPTH_DEF = 16;

  // Field widths of the stream items.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  // Packed widths of tdata, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // What every cell does in a given cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_MATCH,
    CELL_SCAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
  } cell_ctrl_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_state_t;

endpackage

// ===== rtl/core/oale_cell.sv =====
`timescale 1ns / 1ps

// One list slot. Shifts toward higher slots on insert, toward lower slots on
// delete, and passes its match flag toward slot zero during a search scan.
module oale_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                              clk,
  input  oale_pkg::cell_ctrl_t              ctrl,
  input  logic [oale_pkg::VAL_W-1:0]        lo_elem,
  input  logic [oale_pkg::VAL_W-1:0]        hi_elem,
  input  logic                              hi_match,
  output logic [oale_pkg::VAL_W-1:0]        elem_r,
  output logic                              match_r
);

  logic [oale_pkg::VAL_W-1:0] elem_nxt;
  logic                       match_nxt;
  logic                       at_pos;
  logic                       above_pos;

  assign at_pos    = (32'(IDX) == 32'(ctrl.pos));
  assign above_pos = (32'(IDX) >  32'(ctrl.pos));

  always_comb begin
    elem_nxt  = elem_r;
    match_nxt = match_r;
    case (ctrl.op)
      oale_pkg::CELL_INSERT: begin
        if (at_pos) begin
          elem_nxt = ctrl.value;
        end else if (above_pos) begin
          elem_nxt = lo_elem;
        end
      end
      oale_pkg::CELL_DELETE: begin
        if (at_pos || above_pos) begin
          elem_nxt = hi_elem;
        end
      end
      oale_pkg::CELL_MATCH: begin
        match_nxt = (elem_r == ctrl.value);
      end
      oale_pkg::CELL_SCAN: begin
        match_nxt = hi_match;
      end
      default: begin
        elem_nxt  = elem_r;
        match_nxt = match_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    elem_r  <= elem_nxt;
    match_r <= match_nxt;
  end

endmodule

// ===== rtl/core/ordered_array_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Clear, insert, delete and read give their result in the cycle after the input transfer.
// Search first compares every cell at once, then the match flags step one cell per cycle
// toward cell zero until the matching position or the end of the list is reached.
// Throughput: one command per cycle while results are taken at once; a search holds the
// input off until its result is loaded.
// Reset (rst_n low, synchronous) empties the list and the result register; cell contents stay.

module ordered_array_list_engine_unit #(
  parameter int unsigned DEPTH = oale_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Command channel.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: position[3:0], value[35:4], zero fill.
  input  logic [oale_pkg::IN_DATA_W-1:0]     in_tdata,
  // Fields from bit 0: cmd[2:0].
  input  logic [oale_pkg::CMD_W-1:0]         in_tuser,
  // Result channel.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: data[31:0], found_index[35:32], count[40:36], zero fill.
  output logic [oale_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Fields from bit 0: status[1:0].
  output logic [oale_pkg::STATUS_W-1:0]      out_tuser
);

  // The length counter must hold DEPTH itself.
  localparam int unsigned LW = $clog2(DEPTH + 1);
  // Common width for comparing a position against the length.
  localparam int unsigned CW = (LW > oale_pkg::POS_W) ? LW : oale_pkg::POS_W;
  // Only the first sixteen cells can be addressed by a position.
  localparam int unsigned RD_N = (DEPTH < 16) ? DEPTH : 16;

  // Unpacked input fields.
  oale_pkg::cmd_t                    in_cmd;
  logic [oale_pkg::POS_W-1:0]        in_pos;
  logic [oale_pkg::VAL_W-1:0]        in_val;

  assign in_cmd = oale_pkg::cmd_t'(in_tuser);
  assign in_pos = in_tdata[oale_pkg::POS_W-1:0];
  assign in_val = in_tdata[oale_pkg::POS_W +: oale_pkg::VAL_W];

  // Control state.
  oale_pkg::fsm_state_t state_r, state_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [LW-1:0]        scan_idx_r, scan_idx_nxt;

  // Result register.
  logic                             out_valid_r, out_valid_nxt;
  logic [oale_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [oale_pkg::VAL_W-1:0]       data_r, data_nxt;
  logic [oale_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [oale_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic                             out_load;

  // Cell row.
  oale_pkg::cell_ctrl_t             ctrl;
  logic [oale_pkg::VAL_W-1:0]       cell_elem [DEPTH];
  logic                             cell_match [DEPTH];

  logic                             in_xfer;
  logic                             list_full;
  logic                             ins_badpos;
  logic                             pos_in_list;
  logic [oale_pkg::VAL_W-1:0]       rd_data;

  assign in_tready = (state_r == oale_pkg::FSM_IDLE) && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  assign list_full   = (len_r >= LW'(DEPTH));
  assign ins_badpos  = (CW'(in_pos) > CW'(len_r));
  assign pos_in_list = (CW'(in_pos) < CW'(len_r));

  // Read mux over the addressable cells.
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (in_pos == 4'(k)) begin
        rd_data = cell_elem[k];
      end
    end
  end

  // Command decode, search scan and result loading.
  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    scan_idx_nxt = scan_idx_r;
    ctrl.op      = oale_pkg::CELL_HOLD;
    ctrl.pos     = in_pos;
    ctrl.value   = in_val;
    out_load     = 1'b0;
    status_nxt   = oale_pkg::ST_OK;
    data_nxt     = '0;
    idx_nxt      = '0;
    case (state_r)
      oale_pkg::FSM_IDLE: begin
        if (in_xfer) begin
          out_load = 1'b1;
          case (in_cmd)
            oale_pkg::CMD_CLEAR: begin
              len_nxt = '0;
            end
            oale_pkg::CMD_INSERT: begin
              if (list_full) begin
                status_nxt = oale_pkg::ST_FULL;
              end else if (ins_badpos) begin
                status_nxt = oale_pkg::ST_BADPOS;
              end else begin
                ctrl.op = oale_pkg::CELL_INSERT;
                len_nxt = len_r + 1'b1;
              end
            end
            oale_pkg::CMD_DELETE: begin
              if (!pos_in_list) begin
                status_nxt = oale_pkg::ST_BADPOS;
              end else begin
                ctrl.op = oale_pkg::CELL_DELETE;
                len_nxt = len_r - 1'b1;
              end
            end
            oale_pkg::CMD_SEARCH: begin
              // Every cell compares in parallel; the result comes from the scan.
              out_load     = 1'b0;
              ctrl.op      = oale_pkg::CELL_MATCH;
              scan_idx_nxt = '0;
              state_nxt    = oale_pkg::FSM_SCAN;
            end
            oale_pkg::CMD_READ: begin
              if (!pos_in_list) begin
                status_nxt = oale_pkg::ST_BADPOS;
              end else begin
                data_nxt = rd_data;
              end
            end
            default: begin
              status_nxt = oale_pkg::ST_OK;
            end
          endcase
        end
      end
      oale_pkg::FSM_SCAN: begin
        // Cell zero holds the match flag of the slot numbered scan_idx_r.
        if (scan_idx_r == len_r) begin
          out_load   = 1'b1;
          status_nxt = oale_pkg::ST_NOTFOUND;
          state_nxt  = oale_pkg::FSM_IDLE;
        end else if (cell_match[0]) begin
          out_load   = 1'b1;
          idx_nxt    = oale_pkg::IDX_W'(scan_idx_r);
          state_nxt  = oale_pkg::FSM_IDLE;
        end else begin
          ctrl.op      = oale_pkg::CELL_SCAN;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = oale_pkg::FSM_IDLE;
      end
    endcase
    count_nxt = oale_pkg::COUNT_W'(len_nxt);
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oale_pkg::FSM_IDLE;
      len_r       <= '0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      scan_idx_r  <= scan_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
      idx_r    <= idx_nxt;
      count_r  <= count_nxt;
    end
  end

  // The chain of cells: each one sees its lower and upper neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [oale_pkg::VAL_W-1:0] lo_elem;
    logic [oale_pkg::VAL_W-1:0] hi_elem;
    logic                       hi_match;

    if (g == 0) begin : g_first
      assign lo_elem = '0;
    end else begin : g_mid_lo
      assign lo_elem = cell_elem[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign hi_elem  = '0;
      assign hi_match = 1'b0;
    end else begin : g_mid_hi
      assign hi_elem  = cell_elem[g+1];
      assign hi_match = cell_match[g+1];
    end

    oale_cell #(
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .lo_elem  (lo_elem),
      .hi_elem  (hi_elem),
      .hi_match (hi_match),
      .elem_r   (cell_elem[g]),
      .match_r  (cell_match[g])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {7'b0, count_r, idx_r, data_r};

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the ordered list engine. A driver process feeds
// command transfers from a queue that the stimulus block fills. A monitor
// process compares every result transfer with the oldest entry of a queue of
// predicted results. The predictor keeps its own copy of the list and runs
// once for each accepted command transfer.
module tb_top;

  localparam int unsigned LIST_DEPTH  = oale_pkg::DEPTH_DEF;
  localparam int unsigned CMD_W       = oale_pkg::CMD_W;
  localparam int unsigned POS_W       = oale_pkg::POS_W;
  localparam int unsigned VAL_W       = oale_pkg::VAL_W;
  localparam int unsigned IDX_W       = oale_pkg::IDX_W;
  localparam int unsigned COUNT_W     = oale_pkg::COUNT_W;
  localparam int unsigned STATUS_W    = oale_pkg::STATUS_W;
  localparam int unsigned IN_DATA_W   = oale_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W  = oale_pkg::OUT_DATA_W;
  localparam int          RANDOM_CMDS = 1750;
  localparam int          POOL_N      = 10;
  // Slowest correct command is a search miss on a full list.
  localparam int          DRAIN_CYCLES = 2 * LIST_DEPTH + 10;
  // Worst case per command is the longest idle gap on each side plus a full
  // search; two long receiver holds come on top. The limit is several times that.
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 150;
  localparam int          HOLD_SPACING = 500;
  localparam int          MAX_REPORTS = 10;

  // Command codes that the block treats as no operation.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  // Shapes of the random stimulus: mostly growing, mostly shrinking, or mixed.
  typedef enum int {
    EP_GROW,
    EP_SHRINK,
    EP_MIX
  } episode_t;

  typedef struct {
    logic [CMD_W-1:0] code;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               gap;
  } list_cmd_t;

  typedef struct {
    oale_pkg::status_t  st;
    logic [VAL_W-1:0]   data;
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] cnt;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // Fields from bit 0: position[3:0], value[35:4], zero fill.
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // Fields from bit 0: cmd[2:0].
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // Fields from bit 0: data[31:0], found_index[35:32], count[40:36], zero fill.
  logic [OUT_DATA_W-1:0] out_tdata;
  // Fields from bit 0: status[1:0].
  logic [STATUS_W-1:0]   out_tuser;

  // Commands waiting to be offered, and results waiting to be seen.
  list_cmd_t    cmd_q[$];
  list_result_t result_q[$];

  // Predictor state: a private copy of the list contents and its length.
  logic [VAL_W-1:0] model_cells[LIST_DEPTH];
  int               model_len;

  // Stimulus side: the list length the stimulus expects, used only to aim
  // positions at the occupied part of the list.
  int               gen_len;
  logic [VAL_W-1:0] value_pool[POOL_N];
  bit               tx_quiet;

  int  gap_cnt;
  int  rx_wait;
  int  results_seen;
  bit  rx_hold;
  int  hold_left;
  int  holds_done;
  int  err_count;
  int  cycle_count;

  ordered_array_list_engine_unit #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the result of one command and updates the private list copy.
  // Insert checks for a full list before it checks the position.
  task automatic predict_cmd(input logic [CMD_W-1:0] code,
                             input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
    list_result_t r;
    int           k;
    bit           hit;
    r.st   = oale_pkg::ST_OK;
    r.data = '0;
    r.idx  = '0;
    case (code)
      oale_pkg::CMD_CLEAR: begin
        model_len = 0;
      end
      oale_pkg::CMD_INSERT: begin
        if (model_len >= LIST_DEPTH) begin
          r.st = oale_pkg::ST_FULL;
        end else if (pos > model_len) begin
          r.st = oale_pkg::ST_BADPOS;
        end else begin
          for (k = model_len; k > pos; k--) model_cells[k] = model_cells[k-1];
          model_cells[pos] = val;
          model_len++;
        end
      end
      oale_pkg::CMD_DELETE: begin
        if (pos >= model_len) begin
          r.st = oale_pkg::ST_BADPOS;
        end else begin
          for (k = pos; k + 1 < model_len; k++) model_cells[k] = model_cells[k+1];
          model_len--;
        end
      end
      oale_pkg::CMD_SEARCH: begin
        hit = 1'b0;
        for (k = 0; k < model_len && !hit; k++) begin
          if (model_cells[k] == val) begin
            hit   = 1'b1;
            r.idx = k[IDX_W-1:0];
          end
        end
        if (!hit) r.st = oale_pkg::ST_NOTFOUND;
      end
      oale_pkg::CMD_READ: begin
        if (pos >= model_len) r.st = oale_pkg::ST_BADPOS;
        else r.data = model_cells[pos];
      end
      default: begin
      end
    endcase
    r.cnt = model_len[COUNT_W-1:0];
    result_q.push_back(r);
  endtask

  // Queues one command and keeps the stimulus-side length in step.
  task automatic add_cmd(input logic [CMD_W-1:0] code, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val);
    list_cmd_t c;
    c.code = code;
    c.pos  = pos;
    c.val  = val;
    c.gap  = tx_quiet ? 0 : $urandom_range(0, 7);
    cmd_q.push_back(c);
    case (code)
      oale_pkg::CMD_CLEAR:  gen_len = 0;
      oale_pkg::CMD_INSERT: if (gen_len < LIST_DEPTH && pos <= gen_len) gen_len++;
      oale_pkg::CMD_DELETE: if (pos < gen_len) gen_len--;
      default: begin
      end
    endcase
  endtask

  // Values mostly come from a small pool so that searches hit and duplicates
  // occur; the rest are fully random.
  function automatic logic [VAL_W-1:0] draw_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom();
  endfunction

  // A position inside the occupied part most of the time, anywhere otherwise.
  function automatic logic [POS_W-1:0] draw_pos(input int span);
    if (span > 0 && $urandom_range(0, 9) < 8) return POS_W'($urandom_range(0, span - 1));
    return POS_W'($urandom_range(0, 15));
  endfunction

  task automatic report_error(input string msg);
    if (err_count < MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Driver: a command goes out after its own idle gap. A new command can be
  // placed only once the current transfer has happened or nothing is offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_cnt   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_cmd(in_tuser, in_tdata[POS_W-1:0], in_tdata[POS_W +: VAL_W]);
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (gap_cnt < cmd_q[0].gap) begin
          gap_cnt   <= gap_cnt + 1;
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tuser  <= cmd_q[0].code;
          in_tdata  <= {{(IN_DATA_W - POS_W - VAL_W){1'b0}}, cmd_q[0].val, cmd_q[0].pos};
          gap_cnt   <= 0;
          void'(cmd_q.pop_front());
        end
      end
    end
  end

  // Monitor: checks each result transfer and then draws a stall of its own.
  // Every fifth stretch of results runs without any stall.
  always @(posedge clk) begin : result_check
    list_result_t exp_r;
    int           nw;
    if (!rst_n) begin
      out_tready   <= 1'b0;
      rx_wait      <= 0;
      results_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_error($sformatf("result with nothing expected: status=%0d tdata=%h",
                                 out_tuser, out_tdata));
        end else begin
          exp_r = result_q.pop_front();
          if (out_tuser !== exp_r.st || out_tdata[31:0] !== exp_r.data ||
              out_tdata[35:32] !== exp_r.idx || out_tdata[40:36] !== exp_r.cnt ||
              out_tdata[OUT_DATA_W-1:41] !== '0) begin
            report_error({
              $sformatf("result %0d: expected status=%0d data=%h idx=%0d count=%0d, ",
                        results_seen, exp_r.st, exp_r.data, exp_r.idx, exp_r.cnt),
              $sformatf("got status=%0d data=%h idx=%0d count=%0d fill=%h",
                        out_tuser, out_tdata[31:0], out_tdata[35:32], out_tdata[40:36],
                        out_tdata[OUT_DATA_W-1:41])});
          end
        end
        results_seen <= results_seen + 1;
        nw = (((results_seen / 128) % 5) == 4) ? 0 : $urandom_range(0, 7);
        rx_wait    <= nw;
        out_tready <= (nw == 0) && !rx_hold;
      end else if (rx_wait > 0) begin
        rx_wait    <= rx_wait - 1;
        out_tready <= (rx_wait == 1) && !rx_hold;
      end else begin
        out_tready <= !rx_hold;
      end
    end
  end

  // Long receiver hold-offs, counted here in cycles. The driver keeps offering
  // commands meanwhile, so the block backs up and stops taking input.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold    <= 1'b0;
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rx_hold   <= (hold_left > 1);
    end else if (holds_done < 2 && results_seen >= (holds_done + 1) * HOLD_SPACING) begin
      hold_left  <= HOLD_CYCLES;
      rx_hold    <= 1'b1;
      holds_done <= holds_done + 1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Stimulus: a directed opening, then random episodes, then the drain.
  initial begin : stimulus
    episode_t kind;
    int       ep_len;
    int       made;
    int       roll;
    int       t_ins, t_srch, t_rd, t_del, t_clr;
    logic [CMD_W-1:0] code;
    cycle_count = 0;
    err_count   = 0;
    model_len   = 0;
    gen_len     = 0;
    tx_quiet    = 1'b0;
    made        = 0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_N; i++) value_pool[i] = $urandom();

    // Empty list: read, delete and search all fail; an insert past the end fails.
    add_cmd(oale_pkg::CMD_CLEAR, 4'd0, 32'h0);
    add_cmd(oale_pkg::CMD_READ, 4'd0, 32'h0);
    add_cmd(oale_pkg::CMD_DELETE, 4'd0, 32'h0);
    add_cmd(oale_pkg::CMD_SEARCH, 4'd0, 32'h0);
    add_cmd(oale_pkg::CMD_INSERT, 4'd1, 32'h5);
    // Extreme values, an append, an insert at the front and a duplicate.
    add_cmd(oale_pkg::CMD_INSERT, 4'd0, 32'h8000_0000);
    add_cmd(oale_pkg::CMD_INSERT, 4'd1, 32'h7FFF_FFFF);
    add_cmd(oale_pkg::CMD_INSERT, 4'd0, 32'hFFFF_FFFF);
    add_cmd(oale_pkg::CMD_INSERT, 4'd1, 32'h7FFF_FFFF);
    // The first of two equal entries is reported.
    add_cmd(oale_pkg::CMD_SEARCH, 4'd15, 32'h7FFF_FFFF);
    add_cmd(oale_pkg::CMD_READ, 4'd3, 32'h0);
    add_cmd(oale_pkg::CMD_READ, 4'd15, 32'hFFFF_FFFF);
    add_cmd(oale_pkg::CMD_DELETE, 4'd1, 32'h0);
    add_cmd(oale_pkg::CMD_SEARCH, 4'd0, 32'h7FFF_FFFF);
    add_cmd(oale_pkg::CMD_DELETE, 4'd2, 32'h0);
    add_cmd(oale_pkg::CMD_SEARCH, 4'd0, 32'h1234_5678);
    // Unused codes leave the list alone.
    for (logic [CMD_W-1:0] c = CMD_SPARE_FIRST; c != CMD_SPARE_FIRST - 1; c++) begin
      add_cmd(c, POS_W'($urandom_range(0, 15)), $urandom());
      if (c == CMD_SPARE_LAST) break;
    end
    add_cmd(oale_pkg::CMD_READ, 4'd0, 32'h0);
    add_cmd(oale_pkg::CMD_CLEAR, 4'd7, 32'hDEAD_BEEF);

    // Random episodes. Each one leans toward growing the list to full,
    // shrinking it to empty, or a mix, with some noise commands.
    while (made < RANDOM_CMDS) begin
      kind     = episode_t'($urandom_range(0, 2));
      ep_len   = $urandom_range(15, 60);
      tx_quiet = ($urandom_range(0, 5) == 0);
      case (kind)
        EP_GROW: begin
          t_ins = 55; t_srch = 70; t_rd = 85; t_del = 95; t_clr = 96;
        end
        EP_SHRINK: begin
          t_ins = 15; t_srch = 30; t_rd = 45; t_del = 93; t_clr = 95;
        end
        default: begin
          t_ins = 30; t_srch = 52; t_rd = 74; t_del = 94; t_clr = 96;
        end
      endcase
      for (int n = 0; n < ep_len && made < RANDOM_CMDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < t_ins) code = oale_pkg::CMD_INSERT;
        else if (roll < t_srch) code = oale_pkg::CMD_SEARCH;
        else if (roll < t_rd) code = oale_pkg::CMD_READ;
        else if (roll < t_del) code = oale_pkg::CMD_DELETE;
        else if (roll < t_clr) code = oale_pkg::CMD_CLEAR;
        else code = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        case (code)
          oale_pkg::CMD_INSERT: add_cmd(code, draw_pos(gen_len + 1), draw_value());
          oale_pkg::CMD_DELETE, oale_pkg::CMD_READ: begin
            add_cmd(code, draw_pos(gen_len), $urandom());
          end
          default: add_cmd(code, POS_W'($urandom_range(0, 15)), draw_value());
        endcase
        made++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || in_tvalid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
